// ===== src/smbe_pkg.sv =====
// Shared types and constants of the stack-machine bytecode executor.
`timescale 1ns / 1ps

package smbe_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = 11;
    localparam int WORD_W      = 32;
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5,
        OP_NEG  = 3'd6,
        OP_HALT = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_HALT  = 3'd1,
        STAT_OVER  = 3'd2,
        STAT_UNDER = 3'd3,
        STAT_ZDIV  = 3'd4,
        STAT_STOP  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [WORD_W-1:0] constant;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [WORD_W-1:0] value;
        logic [DEPTH_W-1:0]       depth;
    } out_item_t;

    // Divider start request.
    typedef struct packed {
        logic start;
        logic is_mod;
    } div_req_t;

endpackage

// ===== src/stack_machine_bytecode_executor.sv =====
// Top level: stack-machine bytecode executor with cached top and stack memory.
`timescale 1ns / 1ps
// Push, negate, halt and every error/stopped report give a registered result in the
//   cycle after the input transfer; add, sub, mul first pass through FETCH (stack memory
//   read of the second operand); div and mod pass through FETCH and the bit-serial divider.
// Throughput: one item at a time; a new transfer is taken in the cycle the
//   result of the last one is shown, if the output register is free or draining.
// Reset: synchronous, active low; clears stack pointer, stopped flag, FSM and output
//   valid. Stack memory is not cleared, no clearing pass.

module stack_machine_bytecode_executor (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  smbe_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smbe_pkg::out_item_t  m_data
);

    // Stack memory holds every entry below the top; the top word lives in top_reg.
    logic [smbe_pkg::WORD_W-1:0]  stack_mem [smbe_pkg::STACK_DEPTH];
    logic [smbe_pkg::WORD_W-1:0]  below_reg;

    smbe_pkg::state_t             state_reg, state_next;
    logic [smbe_pkg::DEPTH_W-1:0] sp_reg, sp_next;
    logic [smbe_pkg::WORD_W-1:0]  top_reg, top_next;
    logic                         stopped_reg, stopped_next;
    smbe_pkg::op_t                op_reg, op_next;
    logic                         m_valid_reg, m_valid_next;
    smbe_pkg::out_item_t          m_data_reg, m_data_next;

    logic                         s_fire;
    smbe_pkg::op_t                op_in;
    logic                         need_two;
    logic                         underflow;
    logic                         full;
    logic                         zero_div;
    logic                         is_binary;
    logic                         goes_fetch;
    logic [smbe_pkg::WORD_W-1:0]  top_vis;
    logic [smbe_pkg::WORD_W-1:0]  neg_top;
    logic [smbe_pkg::WORD_W-1:0]  alu_res;
    logic [smbe_pkg::DEPTH_W-1:0] sp_dec;
    logic [smbe_pkg::DEPTH_W-1:0] sp_inc;

    logic                         mem_we;
    logic [smbe_pkg::IDX_W-1:0]   mem_waddr;
    logic [smbe_pkg::IDX_W-1:0]   mem_raddr;

    smbe_pkg::div_req_t           div_req;
    logic                         div_done;
    logic [smbe_pkg::WORD_W-1:0]  div_result;

    // ---------------------------------------------------------------- handshake
    assign s_ready = (state_reg == smbe_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------- decode
    assign op_in     = smbe_pkg::op_t'(s_data.operation);
    assign need_two  = !(op_in == smbe_pkg::OP_NEG || op_in == smbe_pkg::OP_HALT);
    assign underflow = need_two ? (sp_reg < smbe_pkg::DEPTH_W'(2))
                                : (sp_reg == '0);
    assign full      = sp_reg >= smbe_pkg::DEPTH_W'(smbe_pkg::STACK_DEPTH);
    assign zero_div  = (op_in == smbe_pkg::OP_DIV || op_in == smbe_pkg::OP_MOD)
                       && (top_reg == '0);
    assign is_binary = need_two && (op_in != smbe_pkg::OP_PUSH);
    assign goes_fetch = !stopped_reg && is_binary && !underflow && !zero_div;

    assign top_vis = (sp_reg == '0) ? '0 : top_reg;
    assign neg_top = '0 - top_reg;
    assign sp_dec  = sp_reg - 1'b1;
    assign sp_inc  = sp_reg + 1'b1;

    // Second operand sits at sp-2; read every cycle, sp is stable through FETCH.
    assign mem_raddr = smbe_pkg::IDX_W'(sp_reg - smbe_pkg::DEPTH_W'(2));
    assign mem_waddr = smbe_pkg::IDX_W'(sp_dec);

    // a = below_reg (deeper entry), b = top_reg
    always_comb begin
        case (op_reg)
            smbe_pkg::OP_ADD: alu_res = below_reg + top_reg;
            smbe_pkg::OP_SUB: alu_res = below_reg - top_reg;
            default:          alu_res = below_reg * top_reg;
        endcase
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smbe_pkg::ST_IDLE: begin
                if (s_fire && goes_fetch) begin
                    state_next = smbe_pkg::ST_FETCH;
                end
            end
            smbe_pkg::ST_FETCH: begin
                if (op_reg == smbe_pkg::OP_DIV || op_reg == smbe_pkg::OP_MOD) begin
                    state_next = smbe_pkg::ST_DIV;
                end else begin
                    state_next = smbe_pkg::ST_IDLE;
                end
            end
            smbe_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = smbe_pkg::ST_IDLE;
                end
            end
            default: state_next = smbe_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        sp_next        = sp_reg;
        top_next       = top_reg;
        stopped_next   = stopped_reg;
        op_next        = op_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        div_req.start  = 1'b0;
        div_req.is_mod = (op_reg == smbe_pkg::OP_MOD);

        unique case (state_reg)
            smbe_pkg::ST_IDLE: begin
                if (s_fire) begin
                    op_next = op_in;
                    if (stopped_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{smbe_pkg::STAT_STOP, top_vis, sp_reg};
                    end else if (op_in == smbe_pkg::OP_PUSH) begin
                        m_valid_next = 1'b1;
                        if (full) begin
                            stopped_next = 1'b1;
                            m_data_next  = '{smbe_pkg::STAT_OVER, top_vis, sp_reg};
                        end else begin
                            // old top spills into memory below the new one
                            mem_we      = (sp_reg != '0);
                            top_next    = s_data.constant;
                            sp_next     = sp_inc;
                            m_data_next = '{smbe_pkg::STAT_OK, s_data.constant, sp_inc};
                        end
                    end else if (underflow) begin
                        stopped_next = 1'b1;
                        m_valid_next = 1'b1;
                        m_data_next  = '{smbe_pkg::STAT_UNDER, top_vis, sp_reg};
                    end else if (op_in == smbe_pkg::OP_HALT) begin
                        sp_next      = '0;
                        m_valid_next = 1'b1;
                        m_data_next  = '{smbe_pkg::STAT_HALT, top_reg, '0};
                    end else if (op_in == smbe_pkg::OP_NEG) begin
                        top_next     = neg_top;
                        m_valid_next = 1'b1;
                        m_data_next  = '{smbe_pkg::STAT_OK, neg_top, sp_reg};
                    end else if (zero_div) begin
                        stopped_next = 1'b1;
                        m_valid_next = 1'b1;
                        m_data_next  = '{smbe_pkg::STAT_ZDIV, top_reg, sp_reg};
                    end
                    // remaining binary ops wait for the memory read in FETCH
                end
            end
            smbe_pkg::ST_FETCH: begin
                if (op_reg == smbe_pkg::OP_DIV || op_reg == smbe_pkg::OP_MOD) begin
                    div_req.start = 1'b1;
                end else begin
                    top_next     = alu_res;
                    sp_next      = sp_dec;
                    m_valid_next = 1'b1;
                    m_data_next  = '{smbe_pkg::STAT_OK, alu_res, sp_dec};
                end
            end
            smbe_pkg::ST_DIV: begin
                if (div_done) begin
                    top_next     = div_result;
                    sp_next      = sp_dec;
                    m_valid_next = 1'b1;
                    m_data_next  = '{smbe_pkg::STAT_OK, div_result, sp_dec};
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- stack memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= top_reg;
        end
        below_reg <= stack_mem[mem_raddr];
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smbe_pkg::ST_IDLE;
            sp_reg      <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            stopped_reg <= stopped_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg    <= top_next;
        op_reg     <= op_next;
        m_data_reg <= m_data_next;
    end

    // ---------------------------------------------------------------- divider
    smbe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (below_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .result   (div_result)
    );

endmodule

// ===== src/smbe_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module smbe_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  smbe_pkg::div_req_t               req,
    input  logic [smbe_pkg::WORD_W-1:0]      dividend,
    input  logic [smbe_pkg::WORD_W-1:0]      divisor,
    output logic                             done,
    output logic [smbe_pkg::WORD_W-1:0]      result
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [smbe_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [smbe_pkg::WORD_W-1:0]       quo_reg, quo_next;
    logic [smbe_pkg::WORD_W-1:0]       rem_reg, rem_next;
    logic [smbe_pkg::WORD_W-1:0]       den_reg, den_next;
    logic                              neg_q_reg, neg_q_next;
    logic                              neg_r_reg, neg_r_next;
    logic                              is_mod_reg, is_mod_next;

    logic [smbe_pkg::WORD_W:0]         rem_sh;
    logic [smbe_pkg::WORD_W:0]         diff;
    logic [smbe_pkg::WORD_W-1:0]       mag_a, mag_b;

    assign mag_a  = dividend[smbe_pkg::WORD_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b  = divisor[smbe_pkg::WORD_W-1]  ? (~divisor + 1'b1)  : divisor;
    assign rem_sh = {rem_reg, quo_reg[smbe_pkg::WORD_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        is_mod_next = is_mod_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            quo_next    = mag_a;
            rem_next    = '0;
            den_next    = mag_b;
            neg_q_next  = dividend[smbe_pkg::WORD_W-1] ^ divisor[smbe_pkg::WORD_W-1];
            neg_r_next  = dividend[smbe_pkg::WORD_W-1];
            is_mod_next = req.is_mod;
        end else if (busy_reg) begin
            if (diff[smbe_pkg::WORD_W]) begin
                rem_next = rem_sh[smbe_pkg::WORD_W-1:0];
                quo_next = {quo_reg[smbe_pkg::WORD_W-2:0], 1'b0};
            end else begin
                rem_next = diff[smbe_pkg::WORD_W-1:0];
                quo_next = {quo_reg[smbe_pkg::WORD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == smbe_pkg::DIV_CNT_W'(smbe_pkg::WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg    <= cnt_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        is_mod_reg <= is_mod_next;
    end

    // Sign fix-up; most-negative / -1 wraps naturally.
    always_comb begin
        if (is_mod_reg) begin
            result = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
        end else begin
            result = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
        end
    end

    assign done = done_reg;

endmodule
